### rtl/jxtc_pkg.sv
`default_nettype none
package jxtc_pkg;

    localparam int POS_BITS    = 16;
    localparam int SPAN_SLOTS  = 4;
    localparam int SLOT_BITS   = $clog2(SPAN_SLOTS);
    localparam int CNT_BITS    = $clog2(SPAN_SLOTS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    // span kinds
    localparam logic [2:0] KIND_PUNCT   = 3'd0;
    localparam logic [2:0] KIND_STRING  = 3'd1;
    localparam logic [2:0] KIND_KEY     = 3'd2;
    localparam logic [2:0] KIND_NUMBER  = 3'd3;
    localparam logic [2:0] KIND_LITERAL = 3'd4;
    localparam logic [2:0] KIND_NAME    = 3'd5;
    localparam logic [2:0] KIND_COMMENT = 3'd6;
    localparam logic [2:0] KIND_END     = 3'd7;

    localparam int DATA_BITS = 3 + 2 * 16;
    localparam int TDATA_BITS = ((DATA_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] start;
        logic [15:0] stop;
    } t_span;

    typedef struct packed {
        logic [CNT_BITS-1:0]        cnt;
        t_span [SPAN_SLOTS-1:0]     spans;
    } t_burst;

endpackage
`default_nettype wire

### rtl/json_xml_token_classifier.sv
`default_nettype none
// Byte-serial JSON/XML token classifier. One text byte per transfer on the
// slave side (tdata = byte, tlast = final byte of the text); classified spans
// come out on the master side, one span per transfer (tdata = kind, start,
// exclusive end; tlast = last span caused by that byte). A byte is taken
// every cycle while the span queue (4 bursts deep) has room: the front end
// classifies a byte combinationally and drops up to 4 spans into the queue
// as one burst, the back end sends them one per cycle while tready is high.
// So steady text runs at 1 byte/cycle; bytes that raise several spans are
// absorbed by the queue. Writing xml_mode (0 JSON, 1 XML) restarts the text
// at offset 0; offsets saturate at 65535. End of text flushes the open token
// and appends an end marker (kind 7) at the offset just past the text.
module json_xml_token_classifier import jxtc_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_wdata,       // xml_mode
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [7:0]             i_s_tdata,         // [7:0] text_byte
    input  wire logic                   i_s_tlast,         // text_end
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [TDATA_BITS-1:0]       o_m_tdata,         // [2:0] kind, [18:3] start, [34:19] end
    output logic                        o_m_tlast          // last_of_run
);

    t_burst burst, head;
    logic   push, pop, empty, full, accept;

    // no combinational path from the master side back to tready
    assign o_s_tready = !full;
    assign accept     = i_s_tvalid && o_s_tready;

    jxtc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_s_tdata),
        .i_end       (i_s_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_burst     (burst),
        .o_push      (push)
    );

    jxtc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_burst (burst),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    jxtc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
`default_nettype wire

### rtl/jxtc_front.sv
`default_nettype none
module jxtc_front import jxtc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_end,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    output t_burst           o_burst,
    output logic             o_push
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_JSTR     = 4'd1;
    localparam logic [3:0] PH_JNUM     = 4'd2;
    localparam logic [3:0] PH_JLIT     = 4'd3;
    localparam logic [3:0] PH_XOPEN    = 4'd4;
    localparam logic [3:0] PH_XMARK    = 4'd5;
    localparam logic [3:0] PH_XNAME    = 4'd6;
    localparam logic [3:0] PH_XATTR    = 4'd7;
    localparam logic [3:0] PH_XVAL     = 4'd8;
    localparam logic [3:0] PH_XKEY     = 4'd9;
    localparam logic [3:0] PH_XCOMMENT = 4'd10;

    function automatic logic is_space(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction
    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic logic name_start(logic [7:0] c);
        return is_alpha(c) || c == "_" || c == ":";
    endfunction
    function automatic logic [POS_BITS-1:0] sat_inc(logic [POS_BITS-1:0] p);
        return (p == POS_MAX) ? POS_MAX : p + 1'b1;
    endfunction
    function automatic t_burst put(t_burst b, logic [2:0] k,
                                   logic [POS_BITS-1:0] s, logic [POS_BITS-1:0] e);
        t_burst r;
        r = b;
        if (b.cnt < CNT_BITS'(SPAN_SLOTS)) begin
            r.spans[b.cnt[SLOT_BITS-1:0]].kind  = k;
            r.spans[b.cnt[SLOT_BITS-1:0]].start = s[15:0];
            r.spans[b.cnt[SLOT_BITS-1:0]].stop  = e[15:0];
            r.cnt = b.cnt + 1'b1;
        end
        return r;
    endfunction

    logic                r_xml;
    logic [3:0]          r_phase, n_phase;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [POS_BITS-1:0] r_ts, n_ts;
    logic [POS_BITS-1:0] r_ps, n_ps;
    logic [POS_BITS-1:0] r_pe, n_pe;
    logic                r_pv, n_pv;
    logic                r_qs, n_qs;
    logic                r_esc, n_esc;
    logic [1:0]          r_dash, n_dash;
    logic [2:0]          r_cl, n_cl;
    t_burst              b;

    always_comb begin
        logic [7:0]          c;
        logic [7:0]          q;
        logic [POS_BITS-1:0] pos;
        logic [POS_BITS-1:0] nxt;
        logic [POS_BITS-1:0] s1;
        logic                done;
        c    = i_byte;
        pos  = r_pos;
        nxt  = sat_inc(r_pos);
        done = 1'b0;
        b    = '0;
        n_phase = r_phase;
        n_ts = r_ts;
        n_ps = r_ps;
        n_pe = r_pe;
        n_pv = r_pv;
        n_qs = r_qs;
        n_esc = r_esc;
        n_dash = r_dash;
        n_cl = r_cl;
        q = r_qs ? 8'h27 : 8'h22;
        s1 = sat_inc(r_ts);

        if (!r_xml) begin
            if (n_phase > PH_JLIT) begin
                n_phase = PH_IDLE;
            end
            if (n_phase == PH_JSTR) begin
                done = 1'b1;
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (c == 8'h5C) begin
                    n_esc = 1'b1;
                end else if (c == q) begin
                    n_ps = r_ts;
                    n_pe = nxt;
                    n_pv = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
            if (!done && n_phase == PH_JNUM) begin
                if (is_digit(c) || c == "." || c == "e" || c == "E" || c == "+" || c == "-") begin
                    done = 1'b1;
                end else begin
                    b = put(b, KIND_NUMBER, r_ts, pos);
                    n_phase = PH_IDLE;
                end
            end
            if (!done && n_phase == PH_JLIT) begin
                if (is_alpha(c)) begin
                    done = 1'b1;
                end else begin
                    b = put(b, KIND_LITERAL, r_ts, pos);
                    n_phase = PH_IDLE;
                end
            end
            if (!done && n_phase == PH_IDLE) begin
                if (r_pv) begin
                    if (is_space(c)) begin
                        done = 1'b1;
                    end else begin
                        b = put(b, (c == ":") ? KIND_KEY : KIND_STRING, r_ps, r_pe);
                        n_pv = 1'b0;
                    end
                end
                if (!done && !is_space(c)) begin
                    if (c == 8'h22 || c == 8'h27) begin
                        n_phase = PH_JSTR;
                        n_ts = pos;
                        n_qs = (c == 8'h27);
                        n_esc = 1'b0;
                    end else if (c == "{" || c == "}" || c == "[" || c == "]"
                                 || c == ":" || c == ",") begin
                        b = put(b, KIND_PUNCT, pos, nxt);
                    end else if (c == "-" || is_digit(c)) begin
                        n_phase = PH_JNUM;
                        n_ts = pos;
                    end else if (is_alpha(c)) begin
                        n_phase = PH_JLIT;
                        n_ts = pos;
                    end
                end
            end
        end else begin
            if (n_phase == PH_JSTR || n_phase == PH_JNUM || n_phase == PH_JLIT
                || n_phase > PH_XCOMMENT) begin
                n_phase = PH_IDLE;
            end
            if (n_phase == PH_IDLE) begin
                done = 1'b1;
                if (c == "<") begin
                    n_phase = PH_XOPEN;
                    n_cl = 3'd1;
                    n_ts = pos;
                end
            end
            if (!done && n_phase == PH_XOPEN) begin
                if (c == ((r_cl == 3'd1) ? "!" : "-")) begin
                    done = 1'b1;
                    n_cl = r_cl + 1'b1;
                    if (n_cl >= 3'd4) begin
                        n_phase = PH_XCOMMENT;
                        n_dash = 2'd0;
                    end
                end else begin
                    b = put(b, KIND_PUNCT, r_ts, s1);
                    n_cl = 3'd0;
                    if (r_cl >= 3'd2) begin
                        b = put(b, KIND_PUNCT, s1, sat_inc(s1));
                        n_phase = (r_cl >= 3'd3) ? PH_XATTR : PH_XMARK;
                    end else begin
                        n_phase = PH_XMARK;
                        if (c == "/" || c == "?") begin
                            b = put(b, KIND_PUNCT, pos, nxt);
                            done = 1'b1;
                        end
                    end
                end
            end
            if (!done && n_phase == PH_XMARK) begin
                if (name_start(c)) begin
                    n_phase = PH_XNAME;
                    n_ts = pos;
                    done = 1'b1;
                end else begin
                    n_phase = PH_XATTR;
                end
            end
            if (!done && n_phase == PH_XNAME) begin
                if (c == ">" || c == "/" || c == " " || c == 8'h09 || c == 8'h0A
                    || c == 8'h0D) begin
                    b = put(b, KIND_NAME, r_ts, pos);
                    n_phase = PH_XATTR;
                end else begin
                    done = 1'b1;
                end
            end
            if (!done && n_phase == PH_XKEY) begin
                if (c == "=" || c == " " || c == 8'h09 || c == ">" || c == "/") begin
                    b = put(b, KIND_KEY, r_ts, pos);
                    n_phase = PH_XATTR;
                end else begin
                    done = 1'b1;
                end
            end
            if (!done && n_phase == PH_XATTR) begin
                done = 1'b1;
                if (c == ">") begin
                    b = put(b, KIND_PUNCT, pos, nxt);
                    n_phase = PH_IDLE;
                end else if (c == 8'h22 || c == 8'h27) begin
                    n_phase = PH_XVAL;
                    n_ts = pos;
                    n_qs = (c == 8'h27);
                end else if (name_start(c)) begin
                    n_phase = PH_XKEY;
                    n_ts = pos;
                end else if (c == "=" || c == "/" || c == "?") begin
                    b = put(b, KIND_PUNCT, pos, nxt);
                end
            end
            if (!done && n_phase == PH_XVAL) begin
                done = 1'b1;
                if (c == q) begin
                    b = put(b, KIND_STRING, r_ts, nxt);
                    n_phase = PH_XATTR;
                end
            end
            if (!done && n_phase == PH_XCOMMENT) begin
                if (c == "-") begin
                    if (r_dash < 2'd2) begin
                        n_dash = r_dash + 1'b1;
                    end
                end else begin
                    if (c == ">" && r_dash >= 2'd2) begin
                        b = put(b, KIND_COMMENT, r_ts, nxt);
                        n_phase = PH_IDLE;
                    end
                    n_dash = 2'd0;
                end
            end
        end

        n_pos = nxt;

        // end of text: flush the open token, then the end marker, then restart
        if (i_end) begin
            if (r_xml) begin
                if (n_phase == PH_XOPEN) begin
                    b = put(b, KIND_PUNCT, n_ts, sat_inc(n_ts));
                    if (n_cl >= 3'd2) begin
                        b = put(b, KIND_PUNCT, sat_inc(n_ts), sat_inc(sat_inc(n_ts)));
                    end
                end else if (n_phase == PH_XNAME) begin
                    b = put(b, KIND_NAME, n_ts, nxt);
                end else if (n_phase == PH_XVAL) begin
                    b = put(b, KIND_STRING, n_ts, nxt);
                end else if (n_phase == PH_XKEY) begin
                    b = put(b, KIND_KEY, n_ts, nxt);
                end else if (n_phase == PH_XCOMMENT) begin
                    b = put(b, KIND_COMMENT, n_ts, nxt);
                end
            end else begin
                if (n_pv) begin
                    b = put(b, KIND_STRING, n_ps, n_pe);
                end
                if (n_phase == PH_JSTR) begin
                    b = put(b, KIND_STRING, n_ts, nxt);
                end else if (n_phase == PH_JNUM) begin
                    b = put(b, KIND_NUMBER, n_ts, nxt);
                end else if (n_phase == PH_JLIT) begin
                    b = put(b, KIND_LITERAL, n_ts, nxt);
                end
            end
            b = put(b, KIND_END, nxt, nxt);
            n_phase = PH_IDLE;
            n_pos = '0;
            n_ts = '0;
            n_ps = '0;
            n_pe = '0;
            n_pv = 1'b0;
            n_qs = 1'b0;
            n_esc = 1'b0;
            n_dash = 2'd0;
            n_cl = 3'd0;
        end
    end

    assign o_burst = b;
    assign o_push  = i_accept && (b.cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_xml   <= i_rst_n ? i_cfg_wdata : 1'b0;
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_ts    <= '0;
            r_ps    <= '0;
            r_pe    <= '0;
            r_pv    <= 1'b0;
            r_qs    <= 1'b0;
            r_esc   <= 1'b0;
            r_dash  <= 2'd0;
            r_cl    <= 3'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_ts    <= n_ts;
            r_ps    <= n_ps;
            r_pe    <= n_pe;
            r_pv    <= n_pv;
            r_qs    <= n_qs;
            r_esc   <= n_esc;
            r_dash  <= n_dash;
            r_cl    <= n_cl;
        end
    end

endmodule
`default_nettype wire

### rtl/jxtc_queue.sv
`default_nettype none
module jxtc_queue import jxtc_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  t_burst      i_burst,
    input  wire logic   i_pop,
    output t_burst      o_head,
    output logic        o_empty,
    output logic        o_full
);

    t_burst                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  r_wr, r_rd;
    logic [QCNT_BITS-1:0]  r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QCNT_BITS'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_burst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_BITS'(i_push) - QCNT_BITS'(i_pop);
        end
    end

endmodule
`default_nettype wire

### rtl/jxtc_back.sv
`default_nettype none
module jxtc_back import jxtc_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  t_burst                      i_head,
    input  wire logic                   i_empty,
    output logic                        o_pop,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [TDATA_BITS-1:0]       o_m_tdata,
    output logic                        o_m_tlast
);

    logic [SLOT_BITS-1:0] r_idx;
    t_span                cur;
    logic                 xfer;

    assign cur        = i_head.spans[r_idx];
    assign o_m_tvalid = !i_empty;
    assign o_m_tlast  = ({1'b0, r_idx} == i_head.cnt - 1'b1);
    assign o_m_tdata  = {{(TDATA_BITS - DATA_BITS){1'b0}}, cur.stop, cur.start, cur.kind};
    assign xfer       = o_m_tvalid && i_m_tready;
    assign o_pop      = xfer && o_m_tlast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (xfer) begin
            r_idx <= o_m_tlast ? '0 : r_idx + 1'b1;
        end
    end

endmodule
`default_nettype wire

### rtl/jxtc_checker.sv
`default_nettype none
module jxtc_checker import jxtc_pkg::*; (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    o_m_tvalid,
    input wire logic                    i_m_tready,
    input wire logic [TDATA_BITS-1:0]   o_m_tdata,
    input wire logic                    o_m_tlast
);

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("tvalid dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("payload changed while stalled");

    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2:0] == KIND_END |->
            o_m_tlast && o_m_tdata[18:3] == o_m_tdata[34:19])
        else $error("end marker malformed");

    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[34:19] >= o_m_tdata[18:3])
        else $error("span ends before it starts");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule

bind json_xml_token_classifier jxtc_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
`default_nettype wire

### verif/tb_json_xml_token_classifier.sv
`timescale 1ns / 1ps

module tb_json_xml_token_classifier;
    import jxtc_pkg::*;

    // scanner phases of the local classifier model
    typedef enum logic [4:0] {
        SC_IDLE, SC_JSTR, SC_JNUM, SC_JLIT, SC_XOPEN, SC_XMARK, SC_XNAME,
        SC_XATTR, SC_XVAL, SC_XKEY, SC_XCOMMENT
    } t_scan;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
    } t_text_byte;

    typedef struct {
        logic [2:0]  kind;
        logic [15:0] start;
        logic [15:0] stop;
        logic        last;
    } t_span_exp;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic                  i_cfg_wdata;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata;   // [7:0] text_byte
    logic                  i_s_tlast;   // text_end
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [TDATA_BITS-1:0] o_m_tdata;   // [2:0] kind, [18:3] start, [34:19] end
    logic                  o_m_tlast;   // last_of_run

    json_xml_token_classifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    // text bytes waiting to be sent and spans waiting to be seen
    t_text_byte text_q[$];
    t_span_exp  span_q[$];

    int  src_idle_pct;
    int  snk_stall_pct;
    bit  byte_taken;
    bit  failed;

    // classifier model state
    logic        m_xml;
    t_scan       m_phase;
    logic [15:0] m_pos, m_tok, m_pstart, m_pend;
    logic        m_pvalid, m_single, m_esc;
    logic [1:0]  m_dashes;
    logic [2:0]  m_open_len;
    t_span_exp   burst[4];
    int          burst_n;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [15:0] sat_inc(logic [15:0] p);
        return (p == 16'hFFFF) ? p : p + 16'd1;
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit starts_name(logic [7:0] c);
        return is_alpha(c) || c == "_" || c == ":";
    endfunction

    task automatic clear_scan();
        m_phase    = SC_IDLE;
        m_pos      = '0;
        m_tok      = '0;
        m_pstart   = '0;
        m_pend     = '0;
        m_pvalid   = 1'b0;
        m_single   = 1'b0;
        m_esc      = 1'b0;
        m_dashes   = '0;
        m_open_len = '0;
    endtask

    task automatic emit(logic [2:0] kind, logic [15:0] s, logic [15:0] e);
        if (burst_n < 4) begin
            burst[burst_n] = '{kind, s, e, 1'b0};
            burst_n++;
        end
    endtask

    task automatic scan_json(logic [7:0] c, logic [15:0] pos, logic [15:0] nxt);
        bit done;
        logic [7:0] q;
        done = 0;
        while (!done) begin
            case (m_phase)
                SC_IDLE: begin
                    done = 1;
                    if (!(m_pvalid && is_space(c))) begin
                        // pending quoted string resolves on the next non-space byte
                        if (m_pvalid) begin
                            emit(c == ":" ? KIND_KEY : KIND_STRING, m_pstart, m_pend);
                            m_pvalid = 1'b0;
                        end
                        if (is_space(c)) begin
                        end else if (c == "\"" || c == "'") begin
                            m_phase  = SC_JSTR;
                            m_tok    = pos;
                            m_single = (c == "'");
                            m_esc    = 1'b0;
                        end else if (c == "{" || c == "}" || c == "[" || c == "]" ||
                                     c == ":" || c == ",") begin
                            emit(KIND_PUNCT, pos, nxt);
                        end else if (c == "-" || is_digit(c)) begin
                            m_phase = SC_JNUM;
                            m_tok   = pos;
                        end else if (is_alpha(c)) begin
                            m_phase = SC_JLIT;
                            m_tok   = pos;
                        end
                    end
                end
                SC_JSTR: begin
                    done = 1;
                    q = m_single ? "'" : "\"";
                    if (m_esc) begin
                        m_esc = 1'b0;
                    end else if (c == "\\") begin
                        m_esc = 1'b1;
                    end else if (c == q) begin
                        m_pstart = m_tok;
                        m_pend   = nxt;
                        m_pvalid = 1'b1;
                        m_phase  = SC_IDLE;
                    end
                end
                SC_JNUM: begin
                    if (is_digit(c) || c == "." || c == "e" || c == "E" || c == "+" ||
                        c == "-") begin
                        done = 1;
                    end else begin
                        emit(KIND_NUMBER, m_tok, pos);
                        m_phase = SC_IDLE;
                    end
                end
                SC_JLIT: begin
                    if (is_alpha(c)) begin
                        done = 1;
                    end else begin
                        emit(KIND_LITERAL, m_tok, pos);
                        m_phase = SC_IDLE;
                    end
                end
                default: m_phase = SC_IDLE;
            endcase
        end
    endtask

    task automatic scan_xml(logic [7:0] c, logic [15:0] pos, logic [15:0] nxt);
        bit done;
        logic [7:0] q;
        logic [15:0] s1;
        done = 0;
        while (!done) begin
            case (m_phase)
                SC_IDLE: begin
                    done = 1;
                    if (c == "<") begin
                        m_phase    = SC_XOPEN;
                        m_open_len = 3'd1;
                        m_tok      = pos;
                    end
                end
                SC_XOPEN: begin
                    // matching "<!--" one byte at a time
                    if (c == (m_open_len == 3'd1 ? "!" : "-")) begin
                        done = 1;
                        m_open_len++;
                        if (m_open_len >= 3'd4) begin
                            m_phase  = SC_XCOMMENT;
                            m_dashes = '0;
                        end
                    end else begin
                        emit(KIND_PUNCT, m_tok, sat_inc(m_tok));
                        if (m_open_len >= 3'd2) begin
                            s1 = sat_inc(m_tok);
                            emit(KIND_PUNCT, s1, sat_inc(s1));
                            m_phase    = (m_open_len >= 3'd3) ? SC_XATTR : SC_XMARK;
                            m_open_len = '0;
                        end else begin
                            m_open_len = '0;
                            m_phase    = SC_XMARK;
                            if (c == "/" || c == "?") begin
                                emit(KIND_PUNCT, pos, nxt);
                                done = 1;
                            end
                        end
                    end
                end
                SC_XMARK: begin
                    if (starts_name(c)) begin
                        m_phase = SC_XNAME;
                        m_tok   = pos;
                        done    = 1;
                    end else begin
                        m_phase = SC_XATTR;
                    end
                end
                SC_XNAME: begin
                    if (c == ">" || c == "/" || c == " " || c == 8'd9 || c == 8'd10 ||
                        c == 8'd13) begin
                        emit(KIND_NAME, m_tok, pos);
                        m_phase = SC_XATTR;
                    end else begin
                        done = 1;
                    end
                end
                SC_XATTR: begin
                    done = 1;
                    if (c == ">") begin
                        emit(KIND_PUNCT, pos, nxt);
                        m_phase = SC_IDLE;
                    end else if (c == "\"" || c == "'") begin
                        m_phase  = SC_XVAL;
                        m_tok    = pos;
                        m_single = (c == "'");
                    end else if (starts_name(c)) begin
                        m_phase = SC_XKEY;
                        m_tok   = pos;
                    end else if (c == "=" || c == "/" || c == "?") begin
                        emit(KIND_PUNCT, pos, nxt);
                    end
                end
                SC_XVAL: begin
                    done = 1;
                    q = m_single ? "'" : "\"";
                    if (c == q) begin
                        emit(KIND_STRING, m_tok, nxt);
                        m_phase = SC_XATTR;
                    end
                end
                SC_XKEY: begin
                    if (c == "=" || c == " " || c == 8'd9 || c == ">" || c == "/") begin
                        emit(KIND_KEY, m_tok, pos);
                        m_phase = SC_XATTR;
                    end else begin
                        done = 1;
                    end
                end
                SC_XCOMMENT: begin
                    done = 1;
                    if (c == "-") begin
                        if (m_dashes < 2'd2) m_dashes++;
                    end else begin
                        if (c == ">" && m_dashes >= 2'd2) begin
                            emit(KIND_COMMENT, m_tok, nxt);
                            m_phase = SC_IDLE;
                        end
                        m_dashes = '0;
                    end
                end
                default: m_phase = SC_IDLE;
            endcase
        end
    endtask

    // end of text: close whatever is open, then the end marker
    task automatic flush_text(logic [15:0] nxt);
        logic [15:0] s1;
        if (m_xml) begin
            case (m_phase)
                SC_XOPEN: begin
                    emit(KIND_PUNCT, m_tok, sat_inc(m_tok));
                    if (m_open_len >= 3'd2) begin
                        s1 = sat_inc(m_tok);
                        emit(KIND_PUNCT, s1, sat_inc(s1));
                    end
                end
                SC_XNAME:    emit(KIND_NAME, m_tok, nxt);
                SC_XVAL:     emit(KIND_STRING, m_tok, nxt);
                SC_XKEY:     emit(KIND_KEY, m_tok, nxt);
                SC_XCOMMENT: emit(KIND_COMMENT, m_tok, nxt);
                default: ;
            endcase
        end else begin
            if (m_pvalid) emit(KIND_STRING, m_pstart, m_pend);
            case (m_phase)
                SC_JSTR: emit(KIND_STRING, m_tok, nxt);
                SC_JNUM: emit(KIND_NUMBER, m_tok, nxt);
                SC_JLIT: emit(KIND_LITERAL, m_tok, nxt);
                default: ;
            endcase
        end
        emit(KIND_END, nxt, nxt);
    endtask

    task automatic classify_byte(logic [7:0] c, logic eot);
        logic [15:0] pos, nxt;
        pos = m_pos;
        nxt = sat_inc(pos);
        burst_n = 0;
        if (m_xml) scan_xml(c, pos, nxt);
        else       scan_json(c, pos, nxt);
        m_pos = nxt;
        if (eot) begin
            flush_text(nxt);
            clear_scan();
        end
        for (int i = 0; i < burst_n; i++) begin
            burst[i].last = (i == burst_n - 1);
            span_q.push_back(burst[i]);
        end
    endtask

    // input side: model update on config writes and accepted text bytes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_taken <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                m_xml = i_cfg_wdata;
                clear_scan();
            end
            if (i_s_tvalid && o_s_tready) classify_byte(i_s_tdata, i_s_tlast);
            byte_taken <= i_s_tvalid && o_s_tready;
        end
    end

    // output side: compare each span transfer with the oldest expected span
    always @(posedge i_clk) begin
        t_span_exp want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (span_q.size() == 0) begin
                $error("span transfer with nothing expected: tdata=%h", o_m_tdata);
                failed = 1;
            end else begin
                want = span_q.pop_front();
                if (o_m_tdata[2:0] !== want.kind) begin
                    $error("span_kind: expected %0d, got %0d", want.kind, o_m_tdata[2:0]);
                    failed = 1;
                end
                if (o_m_tdata[18:3] !== want.start) begin
                    $error("span_start: expected %0d, got %0d", want.start, o_m_tdata[18:3]);
                    failed = 1;
                end
                if (o_m_tdata[34:19] !== want.stop) begin
                    $error("span_end: expected %0d, got %0d", want.stop, o_m_tdata[34:19]);
                    failed = 1;
                end
                if (o_m_tlast !== want.last) begin
                    $error("last_of_run: expected %0d, got %0d", want.last, o_m_tlast);
                    failed = 1;
                end
            end
        end
    end

    // byte driver and output backpressure, both on the falling edge
    always @(negedge i_clk) begin
        t_text_byte nb;
        if (i_rst_n) begin
            i_m_tready <= ($urandom_range(99) >= snk_stall_pct);
            if (!i_s_tvalid || byte_taken) begin
                if (text_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    nb = text_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= nb.ch;
                    i_s_tlast  <= nb.eot;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic queue_text(string s, bit eot);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back('{s[i], eot && (i == s.len() - 1)});
    endtask

    // wait until every byte is in and every span is out, plus the pipe latency
    task automatic drain();
        do @(posedge i_clk);
        while (text_q.size() > 0 || i_s_tvalid || span_q.size() > 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_mode(logic xml);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= xml;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // mostly well-formed fragments with random bytes and text ends mixed in
    task automatic queue_random(logic xml, int n_bytes);
        string jfrag[14] = '{"{", "}", "[", "]", ":", ", ", " \t\n", "\"key\"",
                            "'s\\'q'", "-12.5e+3", "true", "null", "\"a\\\\\" :",
                            "\r\f\v"};
        string xfrag[12] = '{"<a>", "</a>", "<?xml v='1'?>", "<!-- c -- x -->",
                            "<b k='v' j=\"w\"/>", "<!x>", "<n:m >", "text ",
                            "<!-x", "<_q\tk=\"1\">", "<!--->", "< a/>"};
        int start;
        start = text_q.size();
        while (text_q.size() - start < n_bytes) begin
            if ($urandom_range(7) == 0)
                text_q.push_back('{8'($urandom_range(255)), 1'b0});
            else if (xml)
                queue_text(xfrag[$urandom_range(11)], 0);
            else
                queue_text(jfrag[$urandom_range(13)], 0);
            if ($urandom_range(24) == 0) text_q[text_q.size() - 1].eot = 1'b1;
        end
        text_q[text_q.size() - 1].eot = 1'b1;
    endtask

    initial begin
        failed        = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tlast     = 1'b0;
        i_m_tready    = 1'b0;
        m_xml         = 1'b0;
        clear_scan();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // JSON after reset: keys vs strings, escapes, numbers, literals, flushes
        queue_text("{\"k\" :'v\\'x',[-1.5e+3,true]}", 1);
        queue_text("\"ab\\", 1);        // backslash as the final byte
        queue_text("\"p\"  ", 1);       // pending string flushed as string
        queue_text("7", 1);
        queue_text("nul", 1);
        drain();                        // sender pauses until all spans are out

        set_mode(1);
        queue_text("<!-- a-b --->", 0);
        queue_text("<?xml v='1'?><a k=\"v\"/></b>", 1);
        queue_text("<!", 1);            // partial comment opener
        queue_text("<!-", 1);
        queue_text("<n", 1);
        queue_text("<a k", 1);
        queue_text("<a k='v", 1);
        queue_text("<!-- open", 1);

        // random traffic under each idling mix, both modes
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 74; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 74; end
                default: begin src_idle_pct = 21; snk_stall_pct = 21; end
            endcase
            set_mode(p[0]);
            @(posedge i_clk);
            queue_random(p[0], 24);
            set_mode(!p[0]);
            @(posedge i_clk);
            queue_random(!p[0], 24);
        end

        drain();
        if (!failed) $display("SUCCESS");
        else         $display("FAILURE");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

### files.f
rtl/jxtc_pkg.sv
rtl/jxtc_front.sv
rtl/jxtc_queue.sv
rtl/jxtc_back.sv
rtl/json_xml_token_classifier.sv
rtl/jxtc_checker.sv
verif/tb_json_xml_token_classifier.sv
